// File: hdl/mmh64a_pkg.sv
// shared constants and helpers for the murmurhash64a stream block
package mmh64a_pkg;

  localparam logic [63:0] MIX_M = 64'hc6a4a7935bd1e995;
  localparam int unsigned MIX_R = 47;

  localparam logic [31:0] MIX_M_LO = MIX_M[31:0];
  localparam logic [31:0] MIX_M_HI = MIX_M[63:32];

  // keep the low n bytes of a word, n in 0..7
  function automatic logic [63:0] tail_bytes(input logic [63:0] word, input logic [2:0] n);
    logic [63:0] mask;
    begin
      mask = '0;
      for (int b = 0; b < 8; b++) begin
        if (3'(b) < n) begin
          mask[b*8 +: 8] = 8'hff;
        end
      end
      return word & mask;
    end
  endfunction

  // x ^ (x >> r)
  function automatic logic [63:0] xor_shift(input logic [63:0] x);
    return x ^ (x >> MIX_R);
  endfunction

endpackage

// File: hdl/murmur_hash_64a_stream.sv
// murmurhash64a over a stream of little-endian 64-bit words
//
// sequence: a request is accepted in idle, then dispatched to the full, tail or empty
// path; a full word needs 3 multiplies, a tail word 1, an empty word 0; a first
// request adds the length multiply first, a last request adds the finalizer multiply.
// a new request is taken only in idle; every multiply uses the single shared
// 32x32 multiplier that builds each 64-bit product from three partial products;
// a finished hash also holds the finalizer until the output register is free.
// reset (rst, synchronous): seed, running hash and message state clear, output empty.
module murmur_hash_64a_stream (
  input  logic        clk,
  input  logic        rst,
  // seed register
  input  logic        cfg_write,
  input  logic [31:0] cfg_data,
  // request channel
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        first,
  input  logic        last,
  input  logic [30:0] message_length,
  input  logic [63:0] data_word,
  input  logic [3:0]  valid_bytes,
  // result channel
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] hash_value
);

  // sequencer states
  localparam logic [2:0] ST_IDLE = 3'd0;  // waiting for a request
  localparam logic [2:0] ST_LEN  = 3'd1;  // length * m for a new message
  localparam logic [2:0] ST_DISP = 3'd2;  // pick full, tail or empty path
  localparam logic [2:0] ST_K1   = 3'd3;  // k = word * m
  localparam logic [2:0] ST_K2   = 3'd4;  // k = (k ^ k >> r) * m
  localparam logic [2:0] ST_HM   = 3'd5;  // h = h * m
  localparam logic [2:0] ST_FIN  = 3'd6;  // finalizer multiply

  localparam logic [1:0] STEP_LAST = 2'd2;

  logic [2:0]  state;
  logic [1:0]  step;       // partial product index of the current multiply
  logic [31:0] seed;
  logic [63:0] running_hash;
  logic        in_message;
  logic [63:0] opa;        // multiplicand of the shared unit
  logic [63:0] acc;        // partial product accumulator
  logic [63:0] word;       // captured request payload
  logic [3:0]  nbytes;
  logic        last_q;

  logic        mul_state;
  logic        mul_done;
  logic        out_free;
  logic [31:0] mul_a;
  logic [31:0] mul_b;
  logic [63:0] mul_p;
  logic [63:0] mul_term;
  logic [63:0] acc_next;

  assign in_ready = (state == ST_IDLE);
  assign out_free = !out_valid || out_ready;

  assign mul_state = (state == ST_LEN) || (state == ST_K1) || (state == ST_K2) ||
                     (state == ST_HM) || (state == ST_FIN);

  // low 64 bits of opa * m = lo*lo + ((hi*lo + lo*hi) << 32)
  always_comb begin
    unique case (step)
      2'd0:    begin mul_a = opa[31:0];  mul_b = mmh64a_pkg::MIX_M_LO; end
      2'd1:    begin mul_a = opa[63:32]; mul_b = mmh64a_pkg::MIX_M_LO; end
      default: begin mul_a = opa[31:0];  mul_b = mmh64a_pkg::MIX_M_HI; end
    endcase
    mul_p    = {32'b0, mul_a} * {32'b0, mul_b};
    mul_term = (step == 2'd0) ? mul_p : {mul_p[31:0], 32'b0};
    acc_next = ((step == 2'd0) ? 64'b0 : acc) + mul_term;
  end

  // the finalizer result waits here until the output register is free
  assign mul_done = mul_state && (step == STEP_LAST) && ((state != ST_FIN) || out_free);

  always_ff @(posedge clk) begin
    if (rst) begin
      seed <= '0;
    end else if (cfg_write) begin
      seed <= cfg_data;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      word   <= data_word;
      nbytes <= valid_bytes[3] ? 4'd8 : valid_bytes;
      last_q <= last;
    end
    // the last partial product is used straight from acc_next, so a stall holds acc
    if (mul_state && (step != STEP_LAST)) begin
      acc <= acc_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      step         <= '0;
      running_hash <= '0;
      in_message   <= 1'b0;
      out_valid    <= 1'b0;
      opa          <= '0;
      hash_value   <= '0;
    end else begin
      if (out_valid && out_ready && !((state == ST_FIN) && mul_done)) begin
        out_valid <= 1'b0;
      end

      if (mul_state && !mul_done && !(step == STEP_LAST)) begin
        step <= step + 2'd1;
      end else if (mul_done) begin
        step <= '0;
      end

      unique case (state)
        ST_IDLE: begin
          if (in_valid) begin
            if (first) begin
              opa   <= {33'b0, message_length};
              state <= ST_LEN;
            end else if (in_message) begin
              state <= ST_DISP;
            end
            // a request outside a message is dropped
          end
        end
        ST_LEN: begin
          if (mul_done) begin
            running_hash <= {32'b0, seed} ^ acc_next;
            state        <= ST_DISP;
          end
        end
        ST_DISP: begin
          if (nbytes[3]) begin
            opa   <= word;
            state <= ST_K1;
          end else if (nbytes != 4'd0) begin
            opa   <= running_hash ^ mmh64a_pkg::tail_bytes(word, nbytes[2:0]);
            state <= ST_HM;
          end else if (last_q) begin
            opa        <= mmh64a_pkg::xor_shift(running_hash);
            in_message <= 1'b0;
            state      <= ST_FIN;
          end else begin
            in_message <= 1'b1;
            state      <= ST_IDLE;
          end
        end
        ST_K1: begin
          if (mul_done) begin
            opa   <= mmh64a_pkg::xor_shift(acc_next);
            state <= ST_K2;
          end
        end
        ST_K2: begin
          if (mul_done) begin
            opa   <= running_hash ^ acc_next;
            state <= ST_HM;
          end
        end
        ST_HM: begin
          if (mul_done) begin
            running_hash <= acc_next;
            if (last_q) begin
              opa        <= mmh64a_pkg::xor_shift(acc_next);
              in_message <= 1'b0;
              state      <= ST_FIN;
            end else begin
              in_message <= 1'b1;
              state      <= ST_IDLE;
            end
          end
        end
        ST_FIN: begin
          if (mul_done) begin
            hash_value <= mmh64a_pkg::xor_shift(acc_next);
            out_valid  <= 1'b1;
            state      <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // the multiply step counter is parked whenever the sequencer is idle
  a_idle_step: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> (step == 2'd0))
    else $error("step counter not parked in idle");

  // a request outside an open message leaves the block idle
  a_drop_stray: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && !first && !in_message) |=> (state == ST_IDLE))
    else $error("stray request was processed");

  // a request that opens a message starts with the length multiply
  a_first_len: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && first) |=> (state == ST_LEN))
    else $error("first request did not start length multiply");

  // a result only appears from a completed finalizer
  a_out_from_fin: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> ($past(state) == ST_FIN))
    else $error("result produced outside finalizer");

endmodule
